[rtl/mfd_pkg.sv]
package mfd_pkg;

  localparam int LEN_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH   = 4;
  localparam int HDR_BYTES     = 12;
  localparam int SLIDE_BYTES   = 4;
  localparam int CFG_WIDTH     = 24;
  localparam int FILL_WIDTH    = 4;
  localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = CFG_WIDTH'(1024 * 1024);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

endpackage

[rtl/mfd_front.sv]
module mfd_front #(
  parameter int LEN_WIDTH = mfd_pkg::LEN_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [7:0]                     in_byte,
  input  logic [mfd_pkg::CFG_WIDTH-1:0]  max_frame_len,
  output logic                           out_valid,
  output mfd_pkg::word_t                 out_word
);
  import mfd_pkg::*;

  logic [7:0]            header_window [HDR_BYTES];
  logic [FILL_WIDTH-1:0] header_fill;
  logic                  in_frame;
  logic [LEN_WIDTH-1:0]  frame_position;
  logic [LEN_WIDTH-1:0]  frame_total;
  logic [LEN_WIDTH-1:0]  payload_end;

  logic [31:0]          hdr_total;
  logic [31:0]          hdr_plen;
  logic [32:0]          plen_end_wide;
  logic [31:0]          plen_end;
  logic                 fill_done;
  logic                 hdr_bad;
  logic [LEN_WIDTH-1:0] pos_inc;
  logic                 frame_done;

  assign hdr_total = {header_window[3], header_window[2], header_window[1], header_window[0]};
  assign hdr_plen  = {header_window[7], header_window[6], header_window[5], header_window[4]};
  assign fill_done = header_fill == FILL_WIDTH'(HDR_BYTES - 1);

  always_comb begin
    hdr_bad = (hdr_total < 32'(HDR_BYTES))
           || (hdr_total > {{(32 - CFG_WIDTH){1'b0}}, max_frame_len})
           || ((hdr_total >> LEN_WIDTH) != 32'd0);
    plen_end_wide = {1'b0, hdr_plen} + 33'(HDR_BYTES);
    if (plen_end_wide > {1'b0, hdr_total}) begin
      plen_end = hdr_total;
    end else begin
      plen_end = plen_end_wide[31:0];
    end
  end

  assign pos_inc    = frame_position + LEN_WIDTH'(1);
  assign frame_done = pos_inc == frame_total;

  // payload bytes of the current frame go out, the rest is dropped
  assign out_valid     = in_valid && in_frame && (frame_position < payload_end);
  assign out_word.data = in_byte;
  assign out_word.last = pos_inc == payload_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_fill    <= '0;
      in_frame       <= 1'b0;
      frame_position <= '0;
      frame_total    <= '0;
      payload_end    <= '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        header_window[i] <= '0;
      end
    end else if (in_valid) begin
      if (in_frame) begin
        frame_position <= pos_inc;
        if (frame_done) begin
          in_frame    <= 1'b0;
          header_fill <= '0;
        end
      end else if (fill_done && hdr_bad) begin
        // slide the window by four bytes and wait for four more
        for (int i = 0; i < HDR_BYTES - SLIDE_BYTES - 1; i++) begin
          header_window[i] <= header_window[i + SLIDE_BYTES];
        end
        header_window[HDR_BYTES - SLIDE_BYTES - 1] <= in_byte;
        for (int i = HDR_BYTES - SLIDE_BYTES; i < HDR_BYTES; i++) begin
          header_window[i] <= '0;
        end
        header_fill <= FILL_WIDTH'(HDR_BYTES - SLIDE_BYTES);
      end else begin
        header_window[header_fill] <= in_byte;
        if (fill_done) begin
          header_fill    <= '0;
          frame_total    <= hdr_total[LEN_WIDTH-1:0];
          payload_end    <= plen_end[LEN_WIDTH-1:0];
          frame_position <= LEN_WIDTH'(HDR_BYTES);
          in_frame       <= hdr_total != 32'(HDR_BYTES);
        end else begin
          header_fill <= header_fill + FILL_WIDTH'(1);
        end
      end
    end
  end

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (frame_position < frame_total) && (payload_end <= frame_total))
    else $error("frame position or payload end beyond frame total");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    header_fill < FILL_WIDTH'(HDR_BYTES))
    else $error("header fill out of range");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_frame && frame_done) |=> !in_frame && (header_fill == '0))
    else $error("frame did not close at its total length");

endmodule

[rtl/mfd_queue.sv]
module mfd_queue #(
  parameter int DEPTH = mfd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mfd_pkg::word_t wr_word,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output mfd_pkg::word_t rd_word
);
  import mfd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  word_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - CW'(1))
    else $error("queue count did not drop on pop");

endmodule

[rtl/metadata_frame_deframer.sv]
// length-prefixed frame deframer, one stream byte per word
// input: push with data_byte; a word is taken when push is high and full is low
// output: while empty is low, payload_byte and payload_last show the oldest
//   payload word; it is taken when pop is high
// config: cfg_we with cfg_wdata writes max_frame_len; write only while idle
// each frame starts with a 12-byte little-endian header: total length,
//   payload length, flags; a bad total slides the header window by 4 bytes
// a payload byte is registered in the queue and shown after older words pop
// throughput: one byte per cycle while full is low; header check and frame
//   counters settle in the cycle a byte is taken, so bytes enter back to back
// a 4-word queue separates the parser from the receiver; full rises only when
//   the receiver stalls and the queue fills, and drops once a pop is registered
// reset: synchronous on rst; clears the header window, frame state and queue,
//   and sets max_frame_len to 1048576
module metadata_frame_deframer #(
  parameter int LEN_WIDTH   = mfd_pkg::LEN_WIDTH_DEF,
  parameter int QUEUE_DEPTH = mfd_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    data_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    payload_byte,
  output logic                          payload_last,
  input  logic                          cfg_we,
  input  logic [mfd_pkg::CFG_WIDTH-1:0] cfg_wdata
);
  import mfd_pkg::*;

  logic [CFG_WIDTH-1:0] max_frame_len;
  logic                 accept;
  logic                 front_valid;
  word_t                front_word;
  word_t                out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_frame_len <= cfg_wdata;
    end
  end

  assign accept = push && !full;

  mfd_front #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .in_byte      (data_byte),
    .max_frame_len(max_frame_len),
    .out_valid    (front_valid),
    .out_word     (front_word)
  );

  mfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (front_valid),
    .wr_word(front_word),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .rd_word(out_word)
  );

  assign payload_byte = out_word.data;
  assign payload_last = out_word.last;

endmodule
